// ===== src/lap3d_pkg.sv =====
package lap3d_pkg;

    // Width of the edge-length configuration input.
    localparam int CFG_W = 7;

    // Smallest edge length the block works with; smaller writes are raised to it.
    localparam int EDGE_MIN = 3;

    // Status of the item in the first pipeline stage.
    typedef struct packed {
        logic valid;
        logic last;
    } t_s1;

endpackage

// ===== src/lap3d_ctrl.sv =====
module lap3d_ctrl #(
    parameter int MAX_EDGE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lap3d_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_take,
    output logic                                o_accept,
    output logic [$clog2(MAX_EDGE*MAX_EDGE)-1:0] o_addr,
    output logic [$clog2(MAX_EDGE*MAX_EDGE)-1:0] o_addr_next,
    output logic [$clog2(MAX_EDGE*MAX_EDGE)-1:0] o_addr_down,
    output logic [$clog2(MAX_EDGE)-1:0]         o_col,
    output lap3d_pkg::t_s1                      o_s1,
    output logic [$clog2(MAX_EDGE)-1:0]         o_s1_plane,
    output logic [$clog2(MAX_EDGE)-1:0]         o_s1_row,
    output logic [$clog2(MAX_EDGE)-1:0]         o_s1_col
);
    import lap3d_pkg::*;

    localparam int IDX_W  = $clog2(MAX_EDGE);
    localparam int EDGE_W = $clog2(MAX_EDGE + 1);
    localparam int AW     = $clog2(MAX_EDGE * MAX_EDGE);

    logic [EDGE_W-1:0] r_edge;
    logic [IDX_W-1:0]  r_edge_m1;
    logic [IDX_W-1:0]  r_edge_m2;
    logic [IDX_W-1:0]  r_plane;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [AW-1:0]     r_addr;
    logic              r_s1_valid;
    logic              r_s1_last;
    logic [IDX_W-1:0]  r_s1_plane;
    logic [IDX_W-1:0]  r_s1_row;
    logic [IDX_W-1:0]  r_s1_col;

    logic [EDGE_W-1:0] n_edge;
    logic [IDX_W-1:0]  n_plane;
    logic [IDX_W-1:0]  n_row;
    logic [IDX_W-1:0]  n_col;
    logic [AW-1:0]     n_addr;
    logic              col_end;
    logic              row_end;
    logic              interior;
    logic              last;
    logic              accept;

    always_comb begin
        priority if (i_cfg_data < CFG_W'(EDGE_MIN)) begin
            n_edge = EDGE_W'(EDGE_MIN);
        end else if (int'(i_cfg_data) > MAX_EDGE) begin
            n_edge = EDGE_W'(MAX_EDGE);
        end else begin
            n_edge = EDGE_W'(i_cfg_data);
        end
    end

    assign col_end = (r_col == r_edge_m1);
    assign row_end = (r_row == r_edge_m1);

    always_comb begin
        n_col   = r_col + IDX_W'(1);
        n_row   = r_row;
        n_plane = r_plane;
        n_addr  = r_addr + AW'(1);
        if (col_end) begin
            n_col = '0;
            if (row_end) begin
                n_row  = '0;
                n_addr = '0;
                n_plane = (r_plane == r_edge_m1) ? '0 : r_plane + IDX_W'(1);
            end else begin
                n_row = r_row + IDX_W'(1);
            end
        end
    end

    // The sample that completes a centre sits one plane above it.
    assign interior = (r_plane >= IDX_W'(2)) && (r_row != '0) && (r_row <= r_edge_m2)
                   && (r_col != '0) && (r_col <= r_edge_m2);
    assign last     = (r_plane == r_edge_m1) && (r_row == r_edge_m2) && (r_col == r_edge_m2);

    assign o_in_ready = !r_s1_valid || i_take;
    assign accept     = i_in_valid && o_in_ready;
    assign o_accept   = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge     <= EDGE_W'(MAX_EDGE);
            r_edge_m1  <= IDX_W'(MAX_EDGE - 1);
            r_edge_m2  <= IDX_W'(MAX_EDGE - 2);
            r_plane    <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_addr     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_edge    <= n_edge;
                r_edge_m1 <= IDX_W'(n_edge - EDGE_W'(1));
                r_edge_m2 <= IDX_W'(n_edge - EDGE_W'(2));
                r_plane   <= '0;
                r_row     <= '0;
                r_col     <= '0;
                r_addr    <= '0;
            end else if (accept) begin
                r_plane <= n_plane;
                r_row   <= n_row;
                r_col   <= n_col;
                r_addr  <= n_addr;
            end
            if (accept) begin
                r_s1_valid <= interior;
            end else if (i_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last  <= last;
            r_s1_plane <= r_plane - IDX_W'(1);
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
        end
    end

    assign o_addr      = r_addr;
    assign o_addr_next = n_addr;
    assign o_addr_down = r_addr + AW'(r_edge);
    assign o_col       = r_col;
    assign o_s1.valid  = r_s1_valid;
    assign o_s1.last   = r_s1_last;
    assign o_s1_plane  = r_s1_plane;
    assign o_s1_row    = r_s1_row;
    assign o_s1_col    = r_s1_col;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (EDGE_W'(r_col) < r_edge) && (EDGE_W'(r_row) < r_edge) && (EDGE_W'(r_plane) < r_edge))
        else $error("position counter beyond edge length");

    a_addr_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_addr) == 32'(r_row) * 32'(r_edge) + 32'(r_col))
        else $error("plane address out of step with row and column");

    a_interior_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && interior |=> r_s1_valid)
        else $error("interior transfer did not enter the first stage");

endmodule

// ===== src/lap3d_hist.sv =====
module lap3d_hist #(
    parameter int MAX_EDGE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_accept,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic [$clog2(MAX_EDGE*MAX_EDGE)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_EDGE*MAX_EDGE)-1:0] i_rd_addr_a,
    input  logic [$clog2(MAX_EDGE*MAX_EDGE)-1:0] i_rd_addr_b,
    input  logic [$clog2(MAX_EDGE)-1:0]          i_col,
    output logic signed [SAMPLE_BITS-1:0]        o_sample,
    output logic signed [SAMPLE_BITS-1:0]        o_centre,
    output logic signed [SAMPLE_BITS-1:0]        o_back,
    output logic signed [SAMPLE_BITS-1:0]        o_left,
    output logic signed [SAMPLE_BITS-1:0]        o_right,
    output logic signed [SAMPLE_BITS-1:0]        o_up,
    output logic signed [SAMPLE_BITS-1:0]        o_down
);
    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = MAX_EDGE * MAX_EDGE;

    // Each plane entry holds the previous plane in the upper half and the one
    // before it in the lower half, both at the same row and column.
    logic [2*SB-1:0] r_plane_mem [DEPTH];
    logic [SB-1:0]   r_row_mem   [MAX_EDGE];

    logic [2*SB-1:0] r_rd_a;
    logic [SB-1:0]   r_rd_b;
    logic [SB-1:0]   r_rd_up;
    logic [2*SB-1:0] r_h1;
    logic [SB-1:0]   r_h2;
    logic [SB-1:0]   r_sample;

    // The read one entry ahead returns, at the next transfer, the entry that
    // transfer overwrites, so its previous-plane half moves down a slot.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_plane_mem[i_wr_addr] <= {i_sample, r_rd_a[2*SB-1:SB]};
            r_rd_a                 <= r_plane_mem[i_rd_addr_a];
            r_rd_b                 <= r_plane_mem[i_rd_addr_b][2*SB-1:SB];
        end
    end

    // Row buffer of the previous plane: the old entry is the row above.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_row_mem[i_col] <= r_rd_a[2*SB-1:SB];
            r_rd_up          <= r_row_mem[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_h1     <= r_rd_a;
            r_h2     <= r_h1[2*SB-1:SB];
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_centre = r_h1[2*SB-1:SB];
    assign o_back   = r_h1[SB-1:0];
    assign o_left   = r_h2;
    assign o_right  = r_rd_a[2*SB-1:SB];
    assign o_up     = r_rd_up;
    assign o_down   = r_rd_b;

endmodule

// ===== src/lap3d_sum.sv =====
module lap3d_sum #(
    parameter int MAX_EDGE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lap3d_pkg::t_s1                  i_s1,
    input  logic [$clog2(MAX_EDGE)-1:0]     i_plane,
    input  logic [$clog2(MAX_EDGE)-1:0]     i_row,
    input  logic [$clog2(MAX_EDGE)-1:0]     i_col,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic signed [SAMPLE_BITS-1:0]   i_centre,
    input  logic signed [SAMPLE_BITS-1:0]   i_back,
    input  logic signed [SAMPLE_BITS-1:0]   i_left,
    input  logic signed [SAMPLE_BITS-1:0]   i_right,
    input  logic signed [SAMPLE_BITS-1:0]   i_up,
    input  logic signed [SAMPLE_BITS-1:0]   i_down,
    output logic                            o_take,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [SAMPLE_BITS+3:0]   o_laplacian,
    output logic [$clog2(MAX_EDGE)-1:0]     o_out_plane,
    output logic [$clog2(MAX_EDGE)-1:0]     o_out_row,
    output logic [$clog2(MAX_EDGE)-1:0]     o_out_column,
    output logic                            o_last_of_volume
);
    import lap3d_pkg::*;

    localparam int IDX_W = $clog2(MAX_EDGE);
    localparam int SA_W  = SAMPLE_BITS + 2;
    localparam int SB_W  = SAMPLE_BITS + 3;
    localparam int LAP_W = SAMPLE_BITS + 4;

    logic                    r_s2_valid;
    logic signed [SA_W-1:0]  r_sa;
    logic signed [SB_W-1:0]  r_sb;
    logic [IDX_W-1:0]        r_s2_plane;
    logic [IDX_W-1:0]        r_s2_row;
    logic [IDX_W-1:0]        r_s2_col;
    logic                    r_s2_last;
    logic                    r_o_valid;
    logic signed [LAP_W-1:0] r_o_lap;
    logic [IDX_W-1:0]        r_o_plane;
    logic [IDX_W-1:0]        r_o_row;
    logic [IDX_W-1:0]        r_o_col;
    logic                    r_o_last;

    logic signed [SA_W-1:0]  n_sa;
    logic signed [SB_W-1:0]  n_sb;
    logic signed [SB_W-1:0]  centre_x;
    logic                    s2_take;
    logic                    s3_take;

    assign s3_take = !r_o_valid || i_out_ready;
    assign s2_take = !r_s2_valid || s3_take;
    assign o_take  = s2_take;

    // Six times the centre as a sum of two shifts.
    assign centre_x = SB_W'(i_centre);
    assign n_sa = SA_W'(i_sample) + SA_W'(i_back) + SA_W'(i_left) + SA_W'(i_right);
    assign n_sb = SB_W'(i_up) + SB_W'(i_down) - ((centre_x <<< 2) + (centre_x <<< 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_take) begin
                r_s2_valid <= i_s1.valid;
            end
            if (s3_take) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take && i_s1.valid) begin
            r_sa       <= n_sa;
            r_sb       <= n_sb;
            r_s2_plane <= i_plane;
            r_s2_row   <= i_row;
            r_s2_col   <= i_col;
            r_s2_last  <= i_s1.last;
        end
        if (s3_take && r_s2_valid) begin
            r_o_lap   <= LAP_W'(r_sa) + LAP_W'(r_sb);
            r_o_plane <= r_s2_plane;
            r_o_row   <= r_s2_row;
            r_o_col   <= r_s2_col;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_laplacian      = r_o_lap;
    assign o_out_plane      = r_o_plane;
    assign o_out_row        = r_o_row;
    assign o_out_column     = r_o_col;
    assign o_last_of_volume = r_o_last;

    a_last_is_far_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_last |-> (r_o_plane == r_o_row) && (r_o_row == r_o_col))
        else $error("last result is not on the far interior corner");

    a_result_is_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_plane != '0) && (r_o_row != '0) && (r_o_col != '0))
        else $error("result given for a boundary voxel");

endmodule

// ===== src/laplacian_stencil_3d_stream.sv =====
// Seven-point 3-D Laplacian over a streamed cubic volume.
//
// Input channel (i_in_valid / o_in_ready, i_sample): voxels of an E x E x E
// volume in raster order, column fastest. Output channel (o_out_valid /
// i_out_ready): one result per interior centre, given on the transfer of the
// centre's upper-plane neighbor; boundary voxels give nothing.
// Configuration: i_cfg_we writes the edge length, clamped to 3..MAX_EDGE, and
// restarts the position at the first voxel of a new volume. Write it only
// while no result is pending.
// Throughput is one voxel per cycle while the receiver does not stall. The
// plane memory is read one entry ahead, so the taps are registered with the
// input transfer itself; a result then passes the partial-sum register and
// the output register before it is valid. The plane memory (MAX_EDGE*MAX_EDGE
// entries, two samples wide) takes one write and two reads per cycle,
// which sets the one-voxel-per-cycle rate.
// While the receiver stalls, up to three results are held in the pipeline and
// the input keeps taking voxels until they are all occupied.
// Reset clears the position to the volume origin and sets the edge length to
// MAX_EDGE; the sample history needs no clearing, since a result only reads
// entries written during the current volume.
module laplacian_stencil_3d_stream #(
    parameter int MAX_EDGE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lap3d_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS+3:0] o_laplacian,
    output logic [$clog2(MAX_EDGE)-1:0]   o_out_plane,
    output logic [$clog2(MAX_EDGE)-1:0]   o_out_row,
    output logic [$clog2(MAX_EDGE)-1:0]   o_out_column,
    output logic                          o_last_of_volume
);
    import lap3d_pkg::*;

    localparam int IDX_W = $clog2(MAX_EDGE);
    localparam int AW    = $clog2(MAX_EDGE * MAX_EDGE);

    logic                          accept;
    logic                          take;
    logic [AW-1:0]                 addr;
    logic [AW-1:0]                 addr_next;
    logic [AW-1:0]                 addr_down;
    logic [IDX_W-1:0]              col;
    t_s1                           s1;
    logic [IDX_W-1:0]              s1_plane;
    logic [IDX_W-1:0]              s1_row;
    logic [IDX_W-1:0]              s1_col;
    logic signed [SAMPLE_BITS-1:0] tap_sample;
    logic signed [SAMPLE_BITS-1:0] tap_centre;
    logic signed [SAMPLE_BITS-1:0] tap_back;
    logic signed [SAMPLE_BITS-1:0] tap_left;
    logic signed [SAMPLE_BITS-1:0] tap_right;
    logic signed [SAMPLE_BITS-1:0] tap_up;
    logic signed [SAMPLE_BITS-1:0] tap_down;

    lap3d_ctrl #(
        .MAX_EDGE (MAX_EDGE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_take      (take),
        .o_accept    (accept),
        .o_addr      (addr),
        .o_addr_next (addr_next),
        .o_addr_down (addr_down),
        .o_col       (col),
        .o_s1        (s1),
        .o_s1_plane  (s1_plane),
        .o_s1_row    (s1_row),
        .o_s1_col    (s1_col)
    );

    lap3d_hist #(
        .MAX_EDGE    (MAX_EDGE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_wr_addr   (addr),
        .i_rd_addr_a (addr_next),
        .i_rd_addr_b (addr_down),
        .i_col       (col),
        .o_sample    (tap_sample),
        .o_centre    (tap_centre),
        .o_back      (tap_back),
        .o_left      (tap_left),
        .o_right     (tap_right),
        .o_up        (tap_up),
        .o_down      (tap_down)
    );

    lap3d_sum #(
        .MAX_EDGE    (MAX_EDGE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s1             (s1),
        .i_plane          (s1_plane),
        .i_row            (s1_row),
        .i_col            (s1_col),
        .i_sample         (tap_sample),
        .i_centre         (tap_centre),
        .i_back           (tap_back),
        .i_left           (tap_left),
        .i_right          (tap_right),
        .i_up             (tap_up),
        .i_down           (tap_down),
        .o_take           (take),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_laplacian      (o_laplacian),
        .o_out_plane      (o_out_plane),
        .o_out_row        (o_out_row),
        .o_out_column     (o_out_column),
        .o_last_of_volume (o_last_of_volume)
    );

endmodule
